@@ rtl/rvd_pkg.sv @@
package rvd_pkg;

  // format classes as they appear on the result port
  typedef enum logic [2:0] {
    FMT_R     = 3'd0,
    FMT_I     = 3'd1,
    FMT_SHIFT = 3'd2,
    FMT_S     = 3'd3,
    FMT_B     = 3'd4,
    FMT_J     = 3'd5,
    FMT_U     = 3'd6,
    FMT_INVAL = 3'd7
  } format_t;

  // major opcodes of the base integer set
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;

  // funct3 / funct7 codes of the immediate shifts
  localparam logic [2:0] F3_SLLI     = 3'd1;
  localparam logic [2:0] F3_SRLI     = 3'd5;
  localparam logic [6:0] F7_BASE     = 7'h00;
  localparam logic [6:0] F7_ARITH    = 7'h20;

  // one decoded instruction
  typedef struct packed {
    format_t            format_class;
    logic [6:0]         major_opcode;
    logic [2:0]         minor_function;
    logic [6:0]         extended_function;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic signed [31:0] immediate;
    logic               writes_dest;
  } decoded_t;

endpackage

@@ rtl/rvd_decoder.sv @@
module rvd_decoder (
  input  logic [31:0]       instruction,
  output rvd_pkg::decoded_t decoded
);

  logic [6:0] opcode;
  logic [2:0] funct3;
  logic [6:0] top7;
  logic       is_shift;

  assign opcode = instruction[6:0];
  assign funct3 = instruction[14:12];
  assign top7   = instruction[31:25];

  // slli, srli and srai with their standard funct7 only
  assign is_shift = ((funct3 == rvd_pkg::F3_SLLI) && (top7 == rvd_pkg::F7_BASE)) ||
                    ((funct3 == rvd_pkg::F3_SRLI) && ((top7 == rvd_pkg::F7_BASE) ||
                                                      (top7 == rvd_pkg::F7_ARITH)));

  // format class, funct7 and immediate per opcode
  always_comb begin
    decoded.major_opcode      = opcode;
    decoded.minor_function    = funct3;
    decoded.dest_reg          = instruction[11:7];
    decoded.src_reg_a         = instruction[19:15];
    decoded.src_reg_b         = instruction[24:20];
    decoded.extended_function = 7'd0;
    decoded.immediate         = 32'sd0;
    unique case (opcode)
      rvd_pkg::OPC_OP: begin
        decoded.format_class      = rvd_pkg::FMT_R;
        decoded.extended_function = top7;
      end
      rvd_pkg::OPC_OP_IMM: begin
        decoded.extended_function = top7;
        if (is_shift) begin
          decoded.format_class = rvd_pkg::FMT_SHIFT;
          decoded.immediate    = {27'd0, instruction[24:20]};
        end else begin
          decoded.format_class = rvd_pkg::FMT_I;
          decoded.immediate    = {{20{instruction[31]}}, instruction[31:20]};
        end
      end
      rvd_pkg::OPC_LOAD, rvd_pkg::OPC_JALR: begin
        decoded.format_class = rvd_pkg::FMT_I;
        decoded.immediate    = {{20{instruction[31]}}, instruction[31:20]};
      end
      rvd_pkg::OPC_STORE: begin
        decoded.format_class = rvd_pkg::FMT_S;
        decoded.immediate    = {{20{instruction[31]}}, instruction[31:25],
                                instruction[11:7]};
      end
      rvd_pkg::OPC_BRANCH: begin
        decoded.format_class = rvd_pkg::FMT_B;
        decoded.immediate    = {{20{instruction[31]}}, instruction[7],
                                instruction[30:25], instruction[11:8], 1'b0};
      end
      rvd_pkg::OPC_JAL: begin
        decoded.format_class = rvd_pkg::FMT_J;
        decoded.immediate    = {{12{instruction[31]}}, instruction[19:12],
                                instruction[20], instruction[30:21], 1'b0};
      end
      rvd_pkg::OPC_AUIPC, rvd_pkg::OPC_LUI: begin
        decoded.format_class = rvd_pkg::FMT_U;
        decoded.immediate    = {instruction[31:12], 12'd0};
      end
      default: begin
        decoded.format_class = rvd_pkg::FMT_INVAL;
      end
    endcase

    // destination write, also for unknown opcodes
    decoded.writes_dest = (decoded.format_class != rvd_pkg::FMT_S) &&
                          (decoded.format_class != rvd_pkg::FMT_B) &&
                          (instruction[11:7] != 5'd0);
  end

endmodule

@@ rtl/rv32i_instruction_decoder_unit.sv @@
// RV32I instruction decoder. Each transaction on the input channel carries one 32-bit
// instruction word and yields exactly one transaction on the output channel with its
// format class, opcode, funct3, funct7, register numbers, sign-extended immediate and
// destination-write flag. The word is captured in an input register, decoded by one
// level of logic and captured in a result register, which drives the output; a new
// word is taken every cycle while the output is not held; the two
// registers with their valid bits let the input side take one more word while a
// result waits, and a held output stalls the input only once both registers are full.
module rv32i_instruction_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instruction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         format_class,
  output logic [6:0]         major_opcode,
  output logic [2:0]         minor_function,
  output logic [6:0]         extended_function,
  output logic [4:0]         dest_reg,
  output logic [4:0]         src_reg_a,
  output logic [4:0]         src_reg_b,
  output logic signed [31:0] immediate,
  output logic               writes_dest
);

  logic              inst_valid;
  logic [31:0]       inst_reg;
  logic              res_valid;
  rvd_pkg::decoded_t res_reg;
  rvd_pkg::decoded_t decoded;
  logic              res_ready;

  // stage moves when it is empty or its content moves on
  assign res_ready = !res_valid || out_ready;
  assign in_ready  = !inst_valid || res_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inst_valid <= 1'b0;
    end else if (in_ready) begin
      inst_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      inst_reg <= instruction;
    end
  end

  rvd_decoder u_decoder (
    .instruction (inst_reg),
    .decoded     (decoded)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= inst_valid;
    end
    if (res_ready && inst_valid) begin
      res_reg <= decoded;
    end
  end

  // output ports
  assign out_valid         = res_valid;
  assign format_class      = res_reg.format_class;
  assign major_opcode      = res_reg.major_opcode;
  assign minor_function    = res_reg.minor_function;
  assign extended_function = res_reg.extended_function;
  assign dest_reg          = res_reg.dest_reg;
  assign src_reg_a         = res_reg.src_reg_a;
  assign src_reg_b         = res_reg.src_reg_b;
  assign immediate         = res_reg.immediate;
  assign writes_dest       = res_reg.writes_dest;

endmodule

@@ rtl/rvd_checker.sv @@
module rvd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         format_class,
  input logic [6:0]         major_opcode,
  input logic [4:0]         dest_reg,
  input logic [6:0]         extended_function,
  input logic signed [31:0] immediate,
  input logic               writes_dest
);

  // a stalled result transaction holds its format class, immediate and rd
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(format_class) &&
                                $stable(immediate) && $stable(dest_reg))
    else $error("stalled result changed");

  // destination flag agrees with rd and format
  a_writes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> writes_dest == ((dest_reg != 5'd0) &&
                                  (format_class != rvd_pkg::FMT_S) &&
                                  (format_class != rvd_pkg::FMT_B)))
    else $error("destination flag mismatch");

  // no immediate for register-register and unknown opcodes
  a_no_imm: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((format_class == rvd_pkg::FMT_R) ||
                  (format_class == rvd_pkg::FMT_INVAL)) |-> immediate == 32'sd0)
    else $error("immediate not zero");

  // funct7 only for op and op-imm
  a_funct7: assert property (@(posedge clk) disable iff (rst)
    out_valid && (major_opcode != rvd_pkg::OPC_OP) &&
    (major_opcode != rvd_pkg::OPC_OP_IMM) |-> extended_function == 7'd0)
    else $error("funct7 outside op and op-imm");

  // an empty result register always lets the input take a transaction
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind rv32i_instruction_decoder_unit rvd_checker u_rvd_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .format_class      (format_class),
  .major_opcode      (major_opcode),
  .dest_reg          (dest_reg),
  .extended_function (extended_function),
  .immediate         (immediate),
  .writes_dest       (writes_dest)
);

@@ verif/rv32i_instruction_decoder_unit_tb.sv @@
`timescale 1ns / 100ps

module rv32i_instruction_decoder_unit_tb;

  // one expected decode, tagged with the word that caused it
  typedef struct {
    logic [31:0]       word;
    rvd_pkg::decoded_t fields;
  } decode_entry_t;

  // scoreboard: predicts the decode of each accepted word, checks results in order
  class decode_scoreboard;
    decode_entry_t pending_decodes[$];
    int unsigned   failures;
    int unsigned   checked_count;
    int unsigned   format_count[8];

    function void note_instruction(logic [31:0] word);
      decode_entry_t entry;
      entry.word   = word;
      entry.fields = decode_word(word);
      format_count[entry.fields.format_class]++;
      pending_decodes.push_back(entry);
    endfunction

    function int unsigned outstanding();
      return pending_decodes.size();
    endfunction

    // field extraction and immediate assembly per format
    function rvd_pkg::decoded_t decode_word(logic [31:0] w);
      rvd_pkg::decoded_t d;
      d = '0;
      d.format_class   = rvd_pkg::FMT_INVAL;
      d.major_opcode   = w[6:0];
      d.minor_function = w[14:12];
      d.dest_reg       = w[11:7];
      d.src_reg_a      = w[19:15];
      d.src_reg_b      = w[24:20];
      case (w[6:0])
        rvd_pkg::OPC_OP: begin
          d.format_class      = rvd_pkg::FMT_R;
          d.extended_function = w[31:25];
        end
        rvd_pkg::OPC_OP_IMM: begin
          d.extended_function = w[31:25];
          // only the three standard funct3/funct7 pairs count as shifts
          if ((w[14:12] == rvd_pkg::F3_SLLI && w[31:25] == rvd_pkg::F7_BASE) ||
              (w[14:12] == rvd_pkg::F3_SRLI && (w[31:25] == rvd_pkg::F7_BASE ||
                                                w[31:25] == rvd_pkg::F7_ARITH))) begin
            d.format_class = rvd_pkg::FMT_SHIFT;
            d.immediate    = {27'b0, w[24:20]};
          end else begin
            d.format_class = rvd_pkg::FMT_I;
            d.immediate    = {{20{w[31]}}, w[31:20]};
          end
        end
        rvd_pkg::OPC_LOAD, rvd_pkg::OPC_JALR: begin
          d.format_class = rvd_pkg::FMT_I;
          d.immediate    = {{20{w[31]}}, w[31:20]};
        end
        rvd_pkg::OPC_STORE: begin
          d.format_class = rvd_pkg::FMT_S;
          d.immediate    = {{20{w[31]}}, w[31:25], w[11:7]};
        end
        rvd_pkg::OPC_BRANCH: begin
          d.format_class = rvd_pkg::FMT_B;
          d.immediate    = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        rvd_pkg::OPC_JAL: begin
          d.format_class = rvd_pkg::FMT_J;
          d.immediate    = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        rvd_pkg::OPC_AUIPC, rvd_pkg::OPC_LUI: begin
          d.format_class = rvd_pkg::FMT_U;
          d.immediate    = {w[31:12], 12'b0};
        end
        default: begin
          d.format_class = rvd_pkg::FMT_INVAL;
        end
      endcase
      d.writes_dest = (d.format_class != rvd_pkg::FMT_S) &&
                      (d.format_class != rvd_pkg::FMT_B) &&
                      (w[11:7] != 5'd0);
      return d;
    endfunction

    function void compare_field(string name, logic [31:0] word, logic [31:0] exp_val,
                                logic [31:0] act_val);
      if (exp_val !== act_val) begin
        failures++;
        $display("%0t: %s mismatch for instruction %h: expected %h, actual %h",
                 $time, name, word, exp_val, act_val);
      end
    endfunction

    function void check_result(rvd_pkg::decoded_t actual);
      decode_entry_t entry;
      if (pending_decodes.size() == 0) begin
        failures++;
        $display("%0t: result with no instruction outstanding: expected none, actual %h",
                 $time, actual);
        return;
      end
      entry = pending_decodes.pop_front();
      checked_count++;
      compare_field("format_class", entry.word, entry.fields.format_class,
                    actual.format_class);
      compare_field("major_opcode", entry.word, entry.fields.major_opcode,
                    actual.major_opcode);
      compare_field("minor_function", entry.word, entry.fields.minor_function,
                    actual.minor_function);
      compare_field("extended_function", entry.word, entry.fields.extended_function,
                    actual.extended_function);
      compare_field("dest_reg", entry.word, entry.fields.dest_reg, actual.dest_reg);
      compare_field("src_reg_a", entry.word, entry.fields.src_reg_a, actual.src_reg_a);
      compare_field("src_reg_b", entry.word, entry.fields.src_reg_b, actual.src_reg_b);
      compare_field("immediate", entry.word, entry.fields.immediate, actual.immediate);
      compare_field("writes_dest", entry.word, entry.fields.writes_dest,
                    actual.writes_dest);
    endfunction
  endclass

  localparam int RANDOM_PER_PHASE = 184;
  localparam int HOLD_OFF_CYCLES  = 60;

  // opcodes outside the decoded set, used as unknown-opcode stimulus
  localparam logic [6:0] OPC_MISC_MEM = 7'b0001111;
  localparam logic [6:0] OPC_SYSTEM   = 7'b1110011;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        instruction;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         format_class;
  logic [6:0]         major_opcode;
  logic [2:0]         minor_function;
  logic [6:0]         extended_function;
  logic [4:0]         dest_reg;
  logic [4:0]         src_reg_a;
  logic [4:0]         src_reg_b;
  logic signed [31:0] immediate;
  logic               writes_dest;

  decode_scoreboard sb;
  int               tx_idle_pct;
  int               rx_idle_pct;
  int               rx_hold_cycles;
  int unsigned      input_stall_cycles;
  int unsigned      directed_count;

  rv32i_instruction_decoder_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .instruction       (instruction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .format_class      (format_class),
    .major_opcode      (major_opcode),
    .minor_function    (minor_function),
    .extended_function (extended_function),
    .dest_reg          (dest_reg),
    .src_reg_a         (src_reg_a),
    .src_reg_b         (src_reg_b),
    .immediate         (immediate),
    .writes_dest       (writes_dest)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // pack the raw fields of an R-shaped word
  function automatic logic [31:0] encode(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // mostly known opcodes with random content, some pure noise
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    w = $urandom();
    case ($urandom_range(10))
      0: w[6:0] = rvd_pkg::OPC_OP;
      1, 2: w[6:0] = rvd_pkg::OPC_OP_IMM;
      3: w[6:0] = rvd_pkg::OPC_LOAD;
      4: w[6:0] = rvd_pkg::OPC_JALR;
      5: w[6:0] = rvd_pkg::OPC_STORE;
      6: w[6:0] = rvd_pkg::OPC_BRANCH;
      7: w[6:0] = rvd_pkg::OPC_JAL;
      8: w[6:0] = rvd_pkg::OPC_AUIPC;
      9: w[6:0] = rvd_pkg::OPC_LUI;
      default: ;
    endcase
    // steer half the op-imm words onto the shift encodings
    if (w[6:0] == rvd_pkg::OPC_OP_IMM && $urandom_range(1) == 1) begin
      case ($urandom_range(2))
        0: {w[31:25], w[14:12]} = {rvd_pkg::F7_BASE, rvd_pkg::F3_SLLI};
        1: {w[31:25], w[14:12]} = {rvd_pkg::F7_BASE, rvd_pkg::F3_SRLI};
        default: {w[31:25], w[14:12]} = {rvd_pkg::F7_ARITH, rvd_pkg::F3_SRLI};
      endcase
    end
    if ($urandom_range(7) == 0) w[11:7] = 5'd0;
    return w;
  endfunction

  // offer one word, wait for the transaction, then idle at random
  task automatic offer_word(logic [31:0] w);
    @(negedge clk);
    in_valid    <= 1'b1;
    instruction <= w;
    @(posedge clk);
    while (!in_ready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    sb.note_instruction(w);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic run_random(int count);
    repeat (count) offer_word(random_instruction());
  endtask

  // receiver: random back-pressure, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        rx_hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rvd_pkg::decoded_t actual;
    if (!rst && out_valid && out_ready) begin
      actual.format_class      = rvd_pkg::format_t'(format_class);
      actual.major_opcode      = major_opcode;
      actual.minor_function    = minor_function;
      actual.extended_function = extended_function;
      actual.dest_reg          = dest_reg;
      actual.src_reg_a         = src_reg_a;
      actual.src_reg_b         = src_reg_b;
      actual.immediate         = immediate;
      actual.writes_dest       = writes_dest;
      sb.check_result(actual);
    end
  end

  // main sequence
  initial begin
    logic [31:0] directed_words[$];
    sb = new();
    rst                = 1'b1;
    in_valid           = 1'b0;
    instruction        = 32'd0;
    tx_idle_pct        = 9;
    rx_idle_pct        = 51;
    rx_hold_cycles     = 0;
    input_stall_cycles = 0;

    // extremes, every format, the shift corner cases, fence and system
    directed_words.push_back(32'h0000_0000);
    directed_words.push_back(32'hFFFF_FFFF);
    directed_words.push_back(encode(rvd_pkg::F7_BASE, 5'd3, 5'd2, 3'd0, 5'd1,
                                    rvd_pkg::OPC_OP));
    directed_words.push_back(encode(rvd_pkg::F7_ARITH, 5'h1F, 5'h1F, 3'd0, 5'h1F,
                                    rvd_pkg::OPC_OP));
    directed_words.push_back(encode(7'h7F, 5'h1F, 5'h1F, 3'd7, 5'd0, rvd_pkg::OPC_OP));
    directed_words.push_back({12'hFFF, 5'd1, 3'd0, 5'd2, rvd_pkg::OPC_OP_IMM});
    directed_words.push_back({12'h7FF, 5'd0, 3'd7, 5'd0, rvd_pkg::OPC_OP_IMM});
    directed_words.push_back(encode(rvd_pkg::F7_BASE, 5'h1F, 5'd4, rvd_pkg::F3_SLLI, 5'd5,
                                    rvd_pkg::OPC_OP_IMM));
    directed_words.push_back(encode(rvd_pkg::F7_BASE, 5'd0, 5'd4, rvd_pkg::F3_SRLI, 5'd6,
                                    rvd_pkg::OPC_OP_IMM));
    directed_words.push_back(encode(rvd_pkg::F7_ARITH, 5'd17, 5'd4, rvd_pkg::F3_SRLI, 5'd7,
                                    rvd_pkg::OPC_OP_IMM));
    // shift funct3 with a nonstandard funct7 stays an I-type immediate
    directed_words.push_back(encode(rvd_pkg::F7_ARITH, 5'd3, 5'd4, rvd_pkg::F3_SLLI, 5'd8,
                                    rvd_pkg::OPC_OP_IMM));
    directed_words.push_back(encode(7'h01, 5'd3, 5'd4, rvd_pkg::F3_SRLI, 5'd9,
                                    rvd_pkg::OPC_OP_IMM));
    directed_words.push_back({12'h800, 5'd10, 3'd2, 5'd11, rvd_pkg::OPC_LOAD});
    directed_words.push_back({12'h7FF, 5'd1, 3'd0, 5'h1F, rvd_pkg::OPC_JALR});
    directed_words.push_back(encode(7'h7F, 5'd9, 5'd10, 3'd2, 5'h1F, rvd_pkg::OPC_STORE));
    directed_words.push_back(encode(7'h3F, 5'd9, 5'd10, 3'd0, 5'h1F, rvd_pkg::OPC_STORE));
    directed_words.push_back(encode(7'h7F, 5'd1, 5'd2, 3'd1, 5'h1F, rvd_pkg::OPC_BRANCH));
    directed_words.push_back(encode(7'h00, 5'd1, 5'd2, 3'd0, 5'd1, rvd_pkg::OPC_BRANCH));
    directed_words.push_back({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, rvd_pkg::OPC_JAL});
    directed_words.push_back({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd1, rvd_pkg::OPC_JAL});
    directed_words.push_back({20'hFFFFF, 5'd3, rvd_pkg::OPC_AUIPC});
    directed_words.push_back({20'h80000, 5'd0, rvd_pkg::OPC_LUI});
    directed_words.push_back({4'h0, 4'hF, 4'hF, 5'd0, 3'd0, 5'd5, OPC_MISC_MEM});
    directed_words.push_back({25'd0, OPC_SYSTEM});
    directed_count = directed_words.size();

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // slow receiver
    foreach (directed_words[i]) offer_word(directed_words[i]);
    run_random(RANDOM_PER_PHASE);

    // slow sender
    tx_idle_pct = 51;
    rx_idle_pct = 9;
    run_random(RANDOM_PER_PHASE);

    // full rate, starting with a long receiver hold-off so the input backs up
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_cycles = HOLD_OFF_CYCLES;
    run_random(RANDOM_PER_PHASE);

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching for stray results
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("decoded %0d instructions (%0d directed), input stalled %0d cycles",
             sb.checked_count, directed_count, input_stall_cycles);
    $display("formats R/I/shift/S/B/J/U/invalid: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
             sb.format_count[0], sb.format_count[1], sb.format_count[2],
             sb.format_count[3], sb.format_count[4], sb.format_count[5],
             sb.format_count[6], sb.format_count[7]);
    if (sb.failures == 0) begin
      $display("rv32i_instruction_decoder_unit_tb passed");
    end else begin
      $display("rv32i_instruction_decoder_unit_tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", sb.outstanding());
    $display("rv32i_instruction_decoder_unit_tb failed");
    $finish;
  end

endmodule
